[rtl/decimal_integer_formatter_assert.svh]
// ----------------------------------------------------------------------------
// Decimal integer formatter assertion macros
// Shorthand for clocked assertions with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_FORMATTER_ASSERT_SVH
`define DECIMAL_INTEGER_FORMATTER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define DIF_ASSERT_ALWAYS(name, clk_s, rstn_s, cond, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define DIF_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DIF_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dif_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal integer formatter package
// Shared constants and the conversion descriptor passed front to back.
// ----------------------------------------------------------------------------
package dif_pkg;

  localparam int CNT_W       = 6;   // character counts and positions
  localparam int NUM_DIGITS  = 10;  // decimal digits of a 32-bit magnitude
  localparam int DIG_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  // m / 10 == (m * RECIP_10) >> RECIP_SHIFT for any 32-bit m
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // Output layout: [0,b1) spaces, [b1,b2) sign, [b2,b3) zeros,
  // [b3,b4) digits, [b4,total) spaces.
  typedef struct packed {
    logic [7:0]                        sign_ch;
    logic [CNT_W-1:0]                  b1;
    logic [CNT_W-1:0]                  b2;
    logic [CNT_W-1:0]                  b3;
    logic [CNT_W-1:0]                  b4;
    logic [CNT_W-1:0]                  total;
    logic [NUM_DIGITS-1:0][DIG_W-1:0]  digits;  // least significant first
  } desc_t;

endpackage

[rtl/dif_in_if.sv]
// ----------------------------------------------------------------------------
// Formatter input channel
// One integer with its printf conversion flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dif_in_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] value;
  logic               is_unsigned;
  logic [5:0]         field_width;
  logic [5:0]         precision;
  logic               has_precision;
  logic               left_justify;
  logic               zero_pad;
  logic               plus_sign;
  logic               space_sign;

  modport source (
    output valid, value, is_unsigned, field_width, precision, has_precision,
           left_justify, zero_pad, plus_sign, space_sign,
    input  ready
  );
  modport sink (
    input  valid, value, is_unsigned, field_width, precision, has_precision,
           left_justify, zero_pad, plus_sign, space_sign,
    output ready
  );
endinterface

[rtl/dif_out_if.sv]
// ----------------------------------------------------------------------------
// Formatter output channel
// One character per transaction, last flag and count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last;
  logic [5:0] total_count;

  modport source (
    output valid, out_char, char_valid, last, total_count,
    input  ready
  );
  modport sink (
    input  valid, out_char, char_valid, last, total_count,
    output ready
  );
endinterface

[rtl/decimal_integer_formatter.sv]
// ----------------------------------------------------------------------------
// Decimal integer formatter
// printf %d / %i / %u conversion of a 32-bit integer to ASCII characters.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    value, is_unsigned, field_width, precision,
//                                has_precision, left_justify, zero_pad,
//                                plus_sign, space_sign
//  out_ch    out  valid/ready    out_char, char_valid, last, total_count
//
//  Front: takes a new item only once the last is pushed; up to 10 digits come
//  from the one-digit-per-cycle divide-by-ten unit.
//  Back: one character per cycle while out_ch is not stalled; an empty item
//  yields a lone last transaction. A two-entry queue sits between.
//  Reset: synchronous, active low; no clearing pass, ready the cycle after.
//  An output stall holds the back end; the front keeps working until the
//  queue is full.
// ----------------------------------------------------------------------------
module decimal_integer_formatter #(
  parameter int MAX_FIELD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  dif_in_if.sink     in_ch,
  dif_out_if.source  out_ch
);

  logic            push_valid;
  logic            push_ready;
  dif_pkg::desc_t  push_data;
  logic            pop_valid;
  logic            pop_ready;
  dif_pkg::desc_t  pop_data;

  dif_front #(
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dif_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

[rtl/dif_front.sv]
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts an item, resolves sign and flags, extracts one digit per cycle and
// pushes a layout descriptor into the queue.
// ----------------------------------------------------------------------------
`include "decimal_integer_formatter_assert.svh"

module dif_front #(
  parameter int MAX_FIELD = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  dif_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output dif_pkg::desc_t  push_data
);

  localparam logic [dif_pkg::CNT_W-1:0] SAT_LIMIT = dif_pkg::CNT_W'(MAX_FIELD);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [31:0]                                       m_r;
  logic [dif_pkg::DIG_W-1:0]                         nd_r;
  logic [dif_pkg::NUM_DIGITS-1:0][dif_pkg::DIG_W-1:0] dig_r;
  logic [7:0]                                        sign_ch_r;
  logic                                              has_sign_r;
  logic [dif_pkg::CNT_W-1:0]                         width_r;
  logic [dif_pkg::CNT_W-1:0]                         prec_r;
  logic                                              left_r;
  logic                                              zpad_r;

  // accept-side decode
  logic                          accept;
  logic [31:0]                   low;
  logic                          neg;
  logic [31:0]                   mag;
  logic [dif_pkg::CNT_W-1:0]     fw_sat;
  logic [dif_pkg::CNT_W-1:0]     pr_sat;
  logic                          skip_digits;
  logic [7:0]                    sign_ch;
  logic                          has_sign;

  assign accept = in_ch.valid && in_ch.ready;
  assign low    = in_ch.value[31:0];
  assign neg    = !in_ch.is_unsigned && low[31];
  assign mag    = neg ? (32'd0 - low) : low;
  assign fw_sat = (in_ch.field_width > SAT_LIMIT) ? SAT_LIMIT : in_ch.field_width;
  assign pr_sat = !in_ch.has_precision ? '0 :
                  (in_ch.precision > SAT_LIMIT) ? SAT_LIMIT : in_ch.precision;
  assign skip_digits = (mag == 32'd0) && in_ch.has_precision && (pr_sat == '0);

  always_comb begin
    sign_ch  = dif_pkg::CH_NONE;
    has_sign = 1'b0;
    if (!in_ch.is_unsigned) begin
      if (neg) begin
        sign_ch  = dif_pkg::CH_MINUS;
        has_sign = 1'b1;
      end else if (in_ch.plus_sign) begin
        sign_ch  = dif_pkg::CH_PLUS;
        has_sign = 1'b1;
      end else if (in_ch.space_sign) begin
        sign_ch  = dif_pkg::CH_SPACE;
        has_sign = 1'b1;
      end
    end
  end

  // one digit per cycle: quotient by reciprocal, remainder by shift-add
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;

  assign prod = {32'd0, m_r} * {32'd0, dif_pkg::RECIP_10};
  assign quo  = 32'(prod >> dif_pkg::RECIP_SHIFT);
  assign rem  = m_r - ((quo << 3) + (quo << 1));

  assign in_ch.ready = (state_r == F_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = skip_digits ? F_PUSH : F_CONV;
      end
      F_CONV: begin
        if (quo == 32'd0) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_r        <= mag;
      nd_r       <= '0;
      sign_ch_r  <= sign_ch;
      has_sign_r <= has_sign;
      width_r    <= fw_sat;
      prec_r     <= pr_sat;
      left_r     <= in_ch.left_justify;
      zpad_r     <= in_ch.zero_pad && !in_ch.has_precision && !in_ch.left_justify;
    end else if (state_r == F_CONV) begin
      dig_r[nd_r] <= rem[dif_pkg::DIG_W-1:0];
      nd_r        <= nd_r + 1'b1;
      m_r         <= quo;
    end
  end

  // layout of the item from digit count, precision and width
  logic [dif_pkg::CNT_W-1:0] nd_ext;
  logic [dif_pkg::CNT_W-1:0] body;
  logic [dif_pkg::CNT_W-1:0] fixed;
  logic [dif_pkg::CNT_W-1:0] pad;
  logic [dif_pkg::CNT_W-1:0] sgn_ext;

  assign nd_ext  = dif_pkg::CNT_W'(nd_r);
  assign sgn_ext = dif_pkg::CNT_W'(has_sign_r);
  assign body    = (prec_r > nd_ext) ? prec_r : nd_ext;
  assign fixed   = body + sgn_ext;
  assign pad     = (width_r > fixed) ? (width_r - fixed) : '0;

  always_comb begin
    push_data         = '0;
    push_data.sign_ch = sign_ch_r;
    push_data.b1      = (!left_r && !zpad_r) ? pad : '0;
    push_data.b2      = push_data.b1 + sgn_ext;
    push_data.b3      = push_data.b2 + (zpad_r ? pad : '0) + (body - nd_ext);
    push_data.b4      = push_data.b3 + nd_ext;
    push_data.total   = push_data.b4 + (left_r ? pad : '0);
    push_data.digits  = dig_r;
  end

  assign push_valid = (state_r == F_PUSH);

  `DIF_ASSERT_IMPLY(a_front_digit_bound, clk, rst_n, state_r == F_CONV, nd_r < dif_pkg::DIG_W'(dif_pkg::NUM_DIGITS), "front: more than ten digits")

endmodule

[rtl/dif_queue.sv]
// ----------------------------------------------------------------------------
// Formatter descriptor queue
// Two-entry FIFO decoupling digit extraction from character output.
// ----------------------------------------------------------------------------
`include "decimal_integer_formatter_assert.svh"

module dif_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dif_pkg::desc_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dif_pkg::desc_t  pop_data
);

  localparam int PTR_W = $clog2(dif_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dif_pkg::QUEUE_DEPTH + 1);

  dif_pkg::desc_t     mem_r [dif_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(dif_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `DIF_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_r <= CNT_W'(dif_pkg::QUEUE_DEPTH), "queue: occupancy above depth")
  `DIF_ASSERT_NEXT(a_queue_fill, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue: push lost")
  `DIF_ASSERT_IMPLY(a_queue_ptrs, clk, rst_n, count_r == '0 || count_r == CNT_W'(dif_pkg::QUEUE_DEPTH), wr_ptr_r == rd_ptr_r, "queue: pointers disagree with occupancy")

endmodule

[rtl/dif_back.sv]
// ----------------------------------------------------------------------------
// Formatter back end
// Walks head descriptor to output register, one char per unstalled cycle.
// ----------------------------------------------------------------------------
`include "decimal_integer_formatter_assert.svh"

module dif_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  dif_pkg::desc_t  pop_data,
  dif_out_if.source       out_ch
);

  logic [dif_pkg::CNT_W-1:0] k_r;
  logic                      out_valid_r;
  logic [7:0]                out_char_r;
  logic                      char_valid_r;
  logic                      last_r;
  logic [dif_pkg::CNT_W-1:0] total_r;

  logic                      fire;
  logic                      empty_item;
  logic                      is_last;
  logic [dif_pkg::CNT_W-1:0] dig_off;
  logic [dif_pkg::DIG_W-1:0] dig_idx;
  logic [7:0]                ch;

  assign fire       = pop_valid && (!out_valid_r || out_ch.ready);
  assign empty_item = (pop_data.total == '0);
  assign is_last    = empty_item || (k_r == pop_data.total - 1'b1);
  assign pop_ready  = fire && is_last;

  // digits are stored least significant first
  assign dig_off = pop_data.b4 - 1'b1 - k_r;
  assign dig_idx = dig_off[dif_pkg::DIG_W-1:0];

  always_comb begin
    if (k_r < pop_data.b1) begin
      ch = dif_pkg::CH_SPACE;
    end else if (k_r < pop_data.b2) begin
      ch = pop_data.sign_ch;
    end else if (k_r < pop_data.b3) begin
      ch = dif_pkg::CH_ZERO;
    end else if (k_r < pop_data.b4) begin
      ch = dif_pkg::CH_ZERO + 8'(pop_data.digits[dig_idx]);
    end else begin
      ch = dif_pkg::CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        k_r         <= is_last ? '0 : k_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r   <= empty_item ? dif_pkg::CH_NONE : ch;
      char_valid_r <= !empty_item;
      last_r       <= is_last;
      total_r      <= is_last ? pop_data.total : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.char_valid  = char_valid_r;
  assign out_ch.last        = last_r;
  assign out_ch.total_count = total_r;

  `DIF_ASSERT_IMPLY(a_back_empty_last, clk, rst_n, out_valid_r && !char_valid_r, last_r && (total_r == '0), "back: empty result not a lone last")
  `DIF_ASSERT_IMPLY(a_back_count, clk, rst_n, out_valid_r && char_valid_r && last_r, total_r != '0, "back: last character without count")

endmodule

[test/dif_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal integer formatter checker
// Watches both channels, predicts the printf %d / %u character stream for each
// accepted number and compares every result transaction in order.
// ----------------------------------------------------------------------------
module dif_checker #(
  parameter int MAX_FIELD = 32
) (
  input  logic clk,
  input  logic rst_n,
  dif_in_if    in_mon,
  dif_out_if   out_mon,
  output int   mismatches,
  output int   chars_pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       last;
    logic [5:0] total_count;
  } fmt_char_t;

  fmt_char_t expected_chars[$];
  int        n_bad;

  initial begin
    mismatches    = 0;
    chars_pending = 0;
    n_bad         = 0;
  end

  function automatic int unsigned clamp_field(input logic [5:0] v);
    return (v > MAX_FIELD) ? MAX_FIELD : v;
  endfunction

  // Build the characters of one conversion and queue them as expected results.
  function automatic void format_decimal(
    input logic [31:0] low,
    input logic        uns,
    input logic [5:0]  fw,
    input logic [5:0]  prec_in,
    input logic        hp,
    input logic        lj,
    input logic        zp,
    input logic        plus_f,
    input logic        space_f
  );
    int unsigned width;
    int unsigned prec;
    int unsigned nd;
    int unsigned body;
    int unsigned fixed_len;
    int unsigned pad;
    logic [31:0] mag;
    logic [31:0] m;
    logic [7:0]  sign_ch;
    logic        zero_fill;
    logic [7:0]  digs[10];
    logic [7:0]  text[$];
    fmt_char_t   res;

    width     = clamp_field(fw);
    prec      = hp ? clamp_field(prec_in) : 0;
    zero_fill = zp && !hp && !lj;
    mag       = low;
    sign_ch   = dif_pkg::CH_NONE;
    nd        = 0;

    if (!uns) begin
      if (low[31]) begin
        mag     = 32'd0 - low;
        sign_ch = dif_pkg::CH_MINUS;
      end else if (plus_f) begin
        sign_ch = dif_pkg::CH_PLUS;
      end else if (space_f) begin
        sign_ch = dif_pkg::CH_SPACE;
      end
    end

    // zero with an explicit precision of zero prints no digits
    if (!(mag == 32'd0 && hp && prec == 0)) begin
      m = mag;
      do begin
        digs[nd] = dif_pkg::CH_ZERO + 8'(m % 10);
        nd++;
        m = m / 10;
      end while (m != 32'd0);
    end

    body      = (prec > nd) ? prec : nd;
    fixed_len = body + ((sign_ch != dif_pkg::CH_NONE) ? 1 : 0);
    pad       = (width > fixed_len) ? width - fixed_len : 0;

    if (!lj && !zero_fill)
      for (int i = 0; i < pad; i++) text.push_back(dif_pkg::CH_SPACE);
    // sign goes ahead of the padding zeros
    if (sign_ch != dif_pkg::CH_NONE) text.push_back(sign_ch);
    if (zero_fill)
      for (int i = 0; i < pad; i++) text.push_back(dif_pkg::CH_ZERO);
    for (int i = nd; i < body; i++) text.push_back(dif_pkg::CH_ZERO);
    for (int i = nd; i > 0; i--) text.push_back(digs[i-1]);
    if (lj)
      for (int i = 0; i < pad; i++) text.push_back(dif_pkg::CH_SPACE);

    if (text.size() == 0) begin
      res = '{ch: dif_pkg::CH_NONE, char_valid: 1'b0, last: 1'b1, total_count: 6'd0};
      expected_chars.push_back(res);
    end else begin
      foreach (text[i]) begin
        res.ch          = text[i];
        res.char_valid  = 1'b1;
        res.last        = (i == text.size() - 1);
        res.total_count = res.last ? 6'(text.size()) : 6'd0;
        expected_chars.push_back(res);
      end
    end
  endfunction

  always @(posedge clk) begin
    fmt_char_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        format_decimal(in_mon.value[31:0], in_mon.is_unsigned, in_mon.field_width,
                       in_mon.precision, in_mon.has_precision, in_mon.left_justify,
                       in_mon.zero_pad, in_mon.plus_sign, in_mon.space_sign);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result transaction: out_char %0h last %0b",
                 out_mon.out_char, out_mon.last);
          n_bad++;
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.out_char !== want.ch) begin
            $error("out_char: expected %0h actual %0h", want.ch, out_mon.out_char);
            n_bad++;
          end
          if (out_mon.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b actual %0b", want.char_valid,
                   out_mon.char_valid);
            n_bad++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, out_mon.last);
            n_bad++;
          end
          if (out_mon.total_count !== want.total_count) begin
            $error("total_count: expected %0d actual %0d", want.total_count,
                   out_mon.total_count);
            n_bad++;
          end
        end
      end
    end
    mismatches    <= n_bad;
    chars_pending <= expected_chars.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal integer formatter testbench
// Directed corner numbers and flags, then random numbers under three idle
// patterns on both channels; the checker predicts and compares each character.
// ----------------------------------------------------------------------------
module tb;
  localparam int MAX_FIELD  = 32;
  localparam int RAND_ITEMS = 26;  // per idle phase

  logic clk;
  logic rst_n;
  int   in_gap_pct    = 38;
  int   out_stall_pct = 67;
  int   mismatches;
  int   chars_pending;

  dif_in_if  in_ch ();
  dif_out_if out_ch ();

  decimal_integer_formatter #(.MAX_FIELD(MAX_FIELD)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dif_checker #(.MAX_FIELD(MAX_FIELD)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver: stall at random per cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  task automatic send_number(
    input logic signed [32:0] value,
    input logic               uns,
    input logic [5:0]         fw,
    input logic [5:0]         prec,
    input logic               hp,
    input logic               lj,
    input logic               zp,
    input logic               ps,
    input logic               ss
  );
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.value         <= value;
    in_ch.is_unsigned   <= uns;
    in_ch.field_width   <= fw;
    in_ch.precision     <= prec;
    in_ch.has_precision <= hp;
    in_ch.left_justify  <= lj;
    in_ch.zero_pad      <= zp;
    in_ch.plus_sign     <= ps;
    in_ch.space_sign    <= ss;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [32:0] random_number();
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0:       r = $urandom_range(0, 9);
      1:       r = $urandom_range(0, 99999);
      2:       r = $urandom;
      3:       r = 32'd0 - $urandom_range(1, 999);
      default: begin
        case ($urandom_range(0, 3))
          0:       r = 32'h0000_0000;
          1:       r = 32'h8000_0000;
          2:       r = 32'h7FFF_FFFF;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    // sign-extend or zero-extend into the 33-bit field
    return $urandom_range(0, 1) ? $signed({r[31], r}) : $signed({1'b0, r});
  endfunction

  function automatic logic [5:0] random_field();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 32))
                                       : 6'($urandom_range(0, 12));
  endfunction

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++)
      send_number(random_number(), 1'($urandom), random_field(), random_field(),
                  1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.value         = '0;
    in_ch.is_unsigned   = 1'b0;
    in_ch.field_width   = '0;
    in_ch.precision     = '0;
    in_ch.has_precision = 1'b0;
    in_ch.left_justify  = 1'b0;
    in_ch.zero_pad      = 1'b0;
    in_ch.plus_sign     = 1'b0;
    in_ch.space_sign    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // value, uns, width, prec, hp, lj, zp, plus, space
    send_number(33'sd0,           0, 0,  0,  0, 0, 0, 0, 0);
    send_number(33'sd0,           0, 0,  0,  1, 0, 0, 0, 0);  // empty item
    send_number(33'sd0,           1, 0,  0,  1, 0, 0, 1, 1);  // empty, unsigned
    send_number(33'sd0,           0, 5,  0,  1, 0, 0, 0, 0);
    send_number(33'sd0,           0, 0,  0,  1, 0, 0, 1, 0);
    send_number(-33'sd2147483648, 0, 0,  0,  0, 0, 0, 0, 0);
    send_number(33'sd4294967295,  1, 0,  0,  0, 0, 0, 0, 0);
    send_number(33'sd4294967295,  0, 0,  0,  0, 0, 0, 1, 0);
    send_number(33'sd2147483647,  0, 32, 0,  0, 0, 1, 1, 0);
    send_number(-33'sd42,         0, 10, 0,  0, 0, 1, 0, 0);
    send_number(33'sd42,          0, 6,  0,  0, 0, 0, 0, 1);
    send_number(33'sd42,          0, 0,  0,  0, 0, 0, 1, 1);
    send_number(33'sd42,          1, 8,  0,  0, 0, 1, 1, 1);
    send_number(33'sd123,         0, 32, 0,  0, 1, 1, 0, 0);
    send_number(33'sd123,         0, 10, 32, 1, 0, 0, 0, 0);
    send_number(33'sd123,         0, 8,  5,  0, 0, 1, 0, 0);
    send_number(33'sd123,         0, 8,  5,  1, 0, 1, 0, 1);
    send_number(33'sd7,           0, 1,  0,  0, 0, 0, 0, 0);
    send_number(-33'sd1,          0, 6,  3,  1, 1, 0, 1, 0);
    send_number(33'sd1000000000,  0, 31, 31, 1, 1, 0, 0, 1);
    send_number(-33'sd2147483648, 1, 12, 0,  0, 0, 1, 0, 0);

    send_random(RAND_ITEMS);
    in_gap_pct    = 67;
    out_stall_pct = 38;
    send_random(RAND_ITEMS);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_random(RAND_ITEMS);
    in_ch.valid <= 1'b0;

    // let the checker see the last transaction before polling its queue
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dif_pkg.sv
rtl/dif_in_if.sv
rtl/dif_out_if.sv
rtl/dif_front.sv
rtl/dif_queue.sv
rtl/dif_back.sv
rtl/decimal_integer_formatter.sv
test/dif_checker.sv
test/tb.sv
